>>> hdl/yb2b_pkg.sv
// Shared types and constant chroma tables for the 4:2:0 block to BGRA converter.
// No dependencies.
`default_nettype none

package yb2b_pkg;

  localparam int CHROMA_OFFSET = 128;
  localparam int COEF_SCALE    = 10000;
  localparam int COEF_RV       = 14075;
  localparam int COEF_GV       = -7169;
  localparam int COEF_GU       = -3455;
  localparam int COEF_BU       = 17790;

  typedef logic signed [8:0] term_t;
  typedef logic signed [9:0] sum_t;
  typedef logic [255:0][8:0] rom_t;

  // load enables for the two register stages of a submodule
  typedef struct packed {
    logic load_a;
    logic load_b;
  } stage_ld_t;

  // trunc(coef * (i - 128) / 10000), toward zero
  function automatic rom_t build_rom(int coef);
    rom_t r;
    int   d;
    for (int i = 0; i < 256; i++) begin
      d = i - CHROMA_OFFSET;
      r[i] = 9'((coef * d) / COEF_SCALE);
    end
    return r;
  endfunction

  localparam rom_t RV_ROM = build_rom(COEF_RV);
  localparam rom_t GV_ROM = build_rom(COEF_GV);
  localparam rom_t GU_ROM = build_rom(COEF_GU);
  localparam rom_t BU_ROM = build_rom(COEF_BU);

endpackage

`default_nettype wire

>>> hdl/yuv420_block_to_bgra_top.sv
// Channel | dir | handshake           | payload
// in      | in  | in_valid, in_stall  | four luma samples, chroma_u, chroma_v
// out     | out | out_valid, out_stall| blue/green/red of four pixels
//
// Four register stages: table lookup, green term sum, pixel sums, clamp.
// One block is taken every cycle while out_stall is low.
// A stage loads when it is empty or the stage after it moves; in_stall is high
// only when all four stages are full and out_stall is high.
// rst clears the stage valid bits only.
// Top level: pipeline control around yb2b_chroma and four yb2b_pixel units.
// Depends on yb2b_pkg, yb2b_chroma, yb2b_pixel.
`default_nettype none

module yuv420_block_to_bgra_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] luma_top_left,
  input  wire logic [7:0] luma_top_right,
  input  wire logic [7:0] luma_bottom_left,
  input  wire logic [7:0] luma_bottom_right,
  input  wire logic [7:0] chroma_u,
  input  wire logic [7:0] chroma_v,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      blue_top_left,
  output logic [7:0]      green_top_left,
  output logic [7:0]      red_top_left,
  output logic [7:0]      blue_top_right,
  output logic [7:0]      green_top_right,
  output logic [7:0]      red_top_right,
  output logic [7:0]      blue_bottom_left,
  output logic [7:0]      green_bottom_left,
  output logic [7:0]      red_bottom_left,
  output logic [7:0]      blue_bottom_right,
  output logic [7:0]      green_bottom_right,
  output logic [7:0]      red_bottom_right
);
  import yb2b_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vld_next;

  stage_ld_t chroma_ld;
  stage_ld_t pixel_ld;

  logic [3:0][7:0] luma_a;
  logic [3:0][7:0] luma_b;
  logic [3:0][7:0] luma_in;
  logic [3:0][7:0] blue_o;
  logic [3:0][7:0] green_o;
  logic [3:0][7:0] red_o;

  term_t rv_term;
  sum_t  g_term;
  term_t bu_term;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    vld_next[0] = adv[0] ? in_valid : vld[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_next[k] = adv[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  assign chroma_ld.load_a = adv[0];
  assign chroma_ld.load_b = adv[1];
  assign pixel_ld.load_a  = adv[2];
  assign pixel_ld.load_b  = adv[3];

  assign luma_in = {luma_bottom_right, luma_bottom_left, luma_top_right, luma_top_left};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      luma_a <= luma_in;
    end
    if (adv[1]) begin
      luma_b <= luma_a;
    end
  end

  yb2b_chroma u_chroma (
    .clk      (clk),
    .ld       (chroma_ld),
    .chroma_u (chroma_u),
    .chroma_v (chroma_v),
    .rv_term  (rv_term),
    .g_term   (g_term),
    .bu_term  (bu_term)
  );

  for (genvar p = 0; p < 4; p++) begin : g_pix
    yb2b_pixel u_pixel (
      .clk     (clk),
      .ld      (pixel_ld),
      .luma    (luma_b[p]),
      .rv_term (rv_term),
      .g_term  (g_term),
      .bu_term (bu_term),
      .blue    (blue_o[p]),
      .green   (green_o[p]),
      .red     (red_o[p])
    );
  end

  assign blue_top_left      = blue_o[0];
  assign green_top_left     = green_o[0];
  assign red_top_left       = red_o[0];
  assign blue_top_right     = blue_o[1];
  assign green_top_right    = green_o[1];
  assign red_top_right      = red_o[1];
  assign blue_bottom_left   = blue_o[2];
  assign green_bottom_left  = green_o[2];
  assign red_bottom_left    = red_o[2];
  assign blue_bottom_right  = blue_o[3];
  assign green_bottom_right = green_o[3];
  assign red_bottom_right   = red_o[3];

`ifndef SYNTH
  // a free output side never backs up the input
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("in_stall while out_stall low");

  // input stalls only with a full pipe
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&vld) && out_stall))
    else $error("in_stall with a free stage");

  // a filled stage whose successor holds keeps its transfer
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && !adv[2]) |=> vld[1])
    else $error("stage 1 transfer dropped");
`endif

endmodule

`default_nettype wire

>>> hdl/yb2b_chroma.sv
// Chroma path: table lookups, then the combined green term.
// Depends on yb2b_pkg.
`default_nettype none

module yb2b_chroma (
  input  wire logic             clk,
  input  wire yb2b_pkg::stage_ld_t ld,
  input  wire logic [7:0]       chroma_u,
  input  wire logic [7:0]       chroma_v,
  output yb2b_pkg::term_t       rv_term,
  output yb2b_pkg::sum_t        g_term,
  output yb2b_pkg::term_t       bu_term
);
  import yb2b_pkg::*;

  term_t rv_a;
  term_t gv_a;
  term_t gu_a;
  term_t bu_a;

  always_ff @(posedge clk) begin
    if (ld.load_a) begin
      rv_a <= term_t'(RV_ROM[chroma_v]);
      gv_a <= term_t'(GV_ROM[chroma_v]);
      gu_a <= term_t'(GU_ROM[chroma_u]);
      bu_a <= term_t'(BU_ROM[chroma_u]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_b) begin
      rv_term <= rv_a;
      g_term  <= sum_t'(gv_a) + sum_t'(gu_a);
      bu_term <= bu_a;
    end
  end

endmodule

`default_nettype wire

>>> hdl/yb2b_pixel.sv
// One pixel: luma plus chroma terms, then clamp to 0..255.
// Depends on yb2b_pkg.
`default_nettype none

module yb2b_pixel (
  input  wire logic             clk,
  input  wire yb2b_pkg::stage_ld_t ld,
  input  wire logic [7:0]       luma,
  input  wire yb2b_pkg::term_t  rv_term,
  input  wire yb2b_pkg::sum_t   g_term,
  input  wire yb2b_pkg::term_t  bu_term,
  output logic [7:0]            blue,
  output logic [7:0]            green,
  output logic [7:0]            red
);
  import yb2b_pkg::*;

  sum_t y_ext;
  sum_t b_sum;
  sum_t g_sum;
  sum_t r_sum;

  function automatic logic [7:0] sat8(sum_t s);
    logic [7:0] r;
    if (s[9]) begin
      r = 8'd0;
    end else if (s[8]) begin
      r = 8'd255;
    end else begin
      r = s[7:0];
    end
    return r;
  endfunction

  assign y_ext = sum_t'({2'b00, luma});

  always_ff @(posedge clk) begin
    if (ld.load_a) begin
      b_sum <= y_ext + sum_t'(bu_term);
      g_sum <= y_ext + g_term;
      r_sum <= y_ext + sum_t'(rv_term);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load_b) begin
      blue  <= sat8(b_sum);
      green <= sat8(g_sum);
      red   <= sat8(r_sum);
    end
  end

endmodule

`default_nettype wire
